/* hdl/rrbm_pkg.sv */
// shared types and constants for the rom/ram bank mapper
`default_nettype none

package rrbm_pkg;

    // geometry
    localparam int RAM_BANKS      = 16;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_ADDR_W     = $clog2(RAM_DEPTH);
    localparam int RAM_OFF_W      = $clog2(RAM_BANK_BYTES);
    localparam int RAM_BANK_W     = $clog2(RAM_BANKS);
    localparam int ROM_OFF_W      = $clog2(ROM_BANK_BYTES);

    // field widths
    localparam int OP_W       = 2;
    localparam int BUS_ADDR_W = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_ADDR_W = 23;
    localparam int ROM_BANK_W = 9;
    localparam int ROM_CNT_W  = 10;
    localparam int RAM_CNT_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // divider
    localparam int DIV_STEPS = ROM_BANK_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // reset values of the configuration registers
    localparam logic [ROM_CNT_W-1:0] ROM_CNT_RESET = ROM_CNT_W'(2);
    localparam logic [RAM_CNT_W-1:0] RAM_CNT_RESET = RAM_CNT_W'(0);

    // bus address map
    localparam logic [BUS_ADDR_W-1:0] ADDR_BANK_LOW  = 16'h2000;
    localparam logic [BUS_ADDR_W-1:0] ADDR_BANK_HIGH = 16'h3000;
    localparam logic [BUS_ADDR_W-1:0] ADDR_ROM_SEL   = 16'h4000;
    localparam logic [BUS_ADDR_W-1:0] ADDR_RAM_SEL   = 16'h6000;

    localparam logic [3:0]        RAM_EN_KEY   = 4'hA;
    localparam logic [DATA_W-1:0] OPEN_BUS     = 8'hFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROM_BANK_COUNT = 1'b0,
        CFG_RAM_BANK_COUNT = 1'b1
    } cfg_idx_t;

    // bus operations
    typedef enum logic [OP_W-1:0] {
        OP_ROM_READ  = 2'd0,
        OP_ROM_WRITE = 2'd1,
        OP_RAM_READ  = 2'd2,
        OP_RAM_WRITE = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIVIDE,
        ST_RAM_READ,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

/* hdl/rrbm_ram.sv */
// generic single-port ram with registered read
`default_nettype none

module rrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read first port, read data registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* hdl/rom_ram_bank_mapper.sv */
// Cartridge rom/ram bank mapper. Each s_ transfer is one bus access (rom read, rom-area
// register write, ram read or ram write) and gives exactly one m_ transfer. After reset
// the block sweeps the 128 KiB banked ram to zero, one byte a cycle, and holds s_ready
// low until the sweep is done; configuration writes are taken throughout. An item then
// passes from acceptance through decode straight to a result ready for transfer (rom
// read, enable write, ignored writes, ram write, disabled ram read), through a registered
// ram read for an enabled ram read, or through one shared restoring divider for a rom bank
// or ram bank write, which reduces the bank modulo the bank count at one quotient bit a
// cycle. Only in idle is the next item accepted. A result waits in an output register
// until taken; a new item is accepted meanwhile but its own result waits.
`default_nettype none

module rom_ram_bank_mapper (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration
    input  wire logic                             cfg_wr_en,
    input  wire logic [rrbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rrbm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // bus access in
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [rrbm_pkg::OP_W-1:0]        s_opcode,
    input  wire logic [rrbm_pkg::BUS_ADDR_W-1:0]  s_bus_address,
    input  wire logic [rrbm_pkg::DATA_W-1:0]      s_write_data,
    // result out
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [rrbm_pkg::ROM_ADDR_W-1:0]  m_rom_address,
    output logic      [rrbm_pkg::DATA_W-1:0]      m_read_data
);

    import rrbm_pkg::*;

    // configuration registers
    logic [ROM_CNT_W-1:0]  rom_cnt_reg;
    logic [RAM_CNT_W-1:0]  ram_cnt_reg;

    // mapper state
    logic                  ram_en_reg, ram_en_next;
    logic [DATA_W-1:0]     bank_low_reg, bank_low_next;
    logic                  bank_high_reg, bank_high_next;
    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [RAM_BANK_W-1:0] ram_bank_reg, ram_bank_next;

    // sequencer
    state_t                state_reg, state_next;
    logic [RAM_ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    op_t                   op_reg;
    logic [BUS_ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0]     data_reg;

    // shared divider
    logic [ROM_BANK_W-1:0] dvd_reg, dvd_next;
    logic [ROM_CNT_W-1:0]  dvs_reg, dvs_next;
    logic [ROM_CNT_W-1:0]  rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                  div_ram_reg, div_ram_next;
    logic [ROM_CNT_W:0]    trial;
    logic [ROM_CNT_W:0]    trial_diff;

    // result being formed and output register
    logic [ROM_ADDR_W-1:0] res_rom_reg, res_rom_next;
    logic [DATA_W-1:0]     res_data_reg, res_data_next;
    logic                  m_valid_reg, m_valid_next;
    logic [ROM_ADDR_W-1:0] m_rom_reg, m_rom_next;
    logic [DATA_W-1:0]     m_data_reg, m_data_next;

    // ram port
    logic                  mem_we;
    logic [RAM_ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0]     mem_wdata;
    logic [DATA_W-1:0]     mem_rdata;

    // derived views
    logic [RAM_CNT_W-1:0]  ram_eff;
    logic                  ram_present;
    logic                  ram_usable;
    logic [ROM_CNT_W-1:0]  rom_divisor;
    logic                  s_xfer;

    assign ram_eff     = (ram_cnt_reg > RAM_CNT_W'(RAM_BANKS)) ?
                         RAM_CNT_W'(RAM_BANKS) : ram_cnt_reg;
    assign ram_present = (ram_eff != '0);
    assign ram_usable  = ram_present && ram_en_reg;
    assign rom_divisor = (rom_cnt_reg == '0) ? ROM_CNT_W'(1) : rom_cnt_reg;

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_xfer        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_rom_address = m_rom_reg;
    assign m_read_data   = m_data_reg;

    // restoring divider step
    assign trial      = {rem_reg, dvd_reg[ROM_BANK_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_cnt_reg <= ROM_CNT_RESET;
            ram_cnt_reg <= RAM_CNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROM_BANK_COUNT: rom_cnt_reg <= cfg_wr_data;
                CFG_RAM_BANK_COUNT: ram_cnt_reg <= cfg_wr_data[RAM_CNT_W-1:0];
                default:            rom_cnt_reg <= rom_cnt_reg;
            endcase
        end
    end

    // control and mapper state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            ram_en_reg    <= 1'b0;
            bank_low_reg  <= '0;
            bank_high_reg <= 1'b0;
            rom_bank_reg  <= '0;
            ram_bank_reg  <= '0;
            m_valid_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            div_ram_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            ram_en_reg    <= ram_en_next;
            bank_low_reg  <= bank_low_next;
            bank_high_reg <= bank_high_next;
            rom_bank_reg  <= rom_bank_next;
            ram_bank_reg  <= ram_bank_next;
            m_valid_reg   <= m_valid_next;
            div_cnt_reg   <= div_cnt_next;
            div_ram_reg   <= div_ram_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg   <= op_t'(s_opcode);
            addr_reg <= s_bus_address;
            data_reg <= s_write_data;
        end
        dvd_reg      <= dvd_next;
        dvs_reg      <= dvs_next;
        rem_reg      <= rem_next;
        res_rom_reg  <= res_rom_next;
        res_data_reg <= res_data_next;
        m_rom_reg    <= m_rom_next;
        m_data_reg   <= m_data_next;
    end

    // sequencer next state and outputs
    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        ram_en_next    = ram_en_reg;
        bank_low_next  = bank_low_reg;
        bank_high_next = bank_high_reg;
        rom_bank_next  = rom_bank_reg;
        ram_bank_next  = ram_bank_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        div_ram_next   = div_ram_reg;
        res_rom_next   = res_rom_reg;
        res_data_next  = res_data_reg;
        m_valid_next   = m_valid_reg;
        m_rom_next     = m_rom_reg;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_addr       = {ram_bank_reg, addr_reg[RAM_OFF_W-1:0]};
        mem_wdata      = data_reg;

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            // zero the ram after reset
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + RAM_ADDR_W'(1);
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_EXEC;
                end
            end

            // decode the access
            ST_EXEC: begin
                res_rom_next  = '0;
                res_data_next = '0;
                state_next    = ST_RESULT;
                unique case (op_reg)
                    OP_ROM_READ: begin
                        if (addr_reg < ADDR_ROM_SEL) begin
                            res_rom_next = ROM_ADDR_W'(addr_reg);
                        end else begin
                            res_rom_next = {rom_bank_reg, addr_reg[ROM_OFF_W-1:0]};
                        end
                    end
                    OP_ROM_WRITE: begin
                        priority if (addr_reg < ADDR_BANK_LOW) begin
                            ram_en_next = (data_reg[3:0] == RAM_EN_KEY);
                        end else if (addr_reg < ADDR_ROM_SEL) begin
                            dvd_next = {bank_high_reg, bank_low_reg};
                            if (addr_reg < ADDR_BANK_HIGH) begin
                                bank_low_next = data_reg;
                                dvd_next      = {bank_high_reg, data_reg};
                            end else begin
                                bank_high_next = data_reg[0];
                                dvd_next       = {data_reg[0], bank_low_reg};
                            end
                            dvs_next     = rom_divisor;
                            rem_next     = '0;
                            div_cnt_next = '0;
                            div_ram_next = 1'b0;
                            state_next   = ST_DIVIDE;
                        end else if (addr_reg < ADDR_RAM_SEL && ram_present) begin
                            dvd_next     = {1'b0, data_reg};
                            dvs_next     = ROM_CNT_W'(ram_eff);
                            rem_next     = '0;
                            div_cnt_next = '0;
                            div_ram_next = 1'b1;
                            state_next   = ST_DIVIDE;
                        end else begin
                            state_next = ST_RESULT;
                        end
                    end
                    OP_RAM_READ: begin
                        if (ram_usable) begin
                            state_next = ST_RAM_READ;
                        end else begin
                            res_data_next = OPEN_BUS;
                        end
                    end
                    OP_RAM_WRITE: begin
                        mem_we = ram_usable;
                    end
                    default: begin
                        state_next = ST_RESULT;
                    end
                endcase
            end

            // one quotient bit per cycle
            ST_DIVIDE: begin
                if (trial >= {1'b0, dvs_reg}) begin
                    rem_next = trial_diff[ROM_CNT_W-1:0];
                end else begin
                    rem_next = trial[ROM_CNT_W-1:0];
                end
                dvd_next     = {dvd_reg[ROM_BANK_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    if (div_ram_reg) begin
                        ram_bank_next = rem_next[RAM_BANK_W-1:0];
                    end else begin
                        rom_bank_next = rem_next[ROM_BANK_W-1:0];
                    end
                    state_next = ST_RESULT;
                end
            end

            // registered ram data is available now
            ST_RAM_READ: begin
                res_data_next = mem_rdata;
                state_next    = ST_RESULT;
            end

            // hand the result to the output register once it is free
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rom_next   = res_rom_reg;
                    m_data_next  = res_data_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // banked cartridge ram
    rrbm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
